// ===== hw/rtl/ihq_pkg.sv =====
// Shared types and constants for the indexed min-heap queue.
package ihq_pkg;

  localparam int unsigned CAPACITY_DEF  = 256;
  localparam int unsigned ID_COUNT_DEF  = 256;
  localparam int unsigned KEY_WIDTH_DEF = 32;

  localparam int unsigned ID_FIELD_W    = 8;
  localparam int unsigned POS_FIELD_W   = 8;
  localparam int unsigned TOTAL_W       = 9;

  typedef enum logic [2:0] {
    OP_INSERT   = 3'd0,
    OP_EXTRACT  = 3'd1,
    OP_REMOVE   = 3'd2,
    OP_DECREASE = 3'd3,
    OP_SEARCH   = 3'd4
  } op_e;

  typedef enum logic [2:0] {
    STAT_OK       = 3'd0,
    STAT_EMPTY    = 3'd1,
    STAT_FULL     = 3'd2,
    STAT_NOTFOUND = 3'd3,
    STAT_BADPOS   = 3'd4,
    STAT_DUP      = 3'd5
  } status_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_POS,
    ST_LAST,
    ST_DEC,
    ST_UP,
    ST_UP_CMP,
    ST_DOWN,
    ST_DOWN_L,
    ST_DOWN_R,
    ST_PLACE,
    ST_SCAN,
    ST_DONE
  } state_e;

endpackage

// ===== hw/rtl/ihq_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
module ihq_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/indexed_min_heap_queue.sv =====
// Indexed binary min-heap queue: sequencer around a heap RAM and an id-to-position RAM.
//
//  channel  | ports                                 | transfer
//  ---------+---------------------------------------+---------------------------
//  command  | op_i key_i id_i position_i            | start_i high, busy_o low
//  result   | status_o found_o removed_* min_* ...  | done_o high for one cycle
//
// Each sift level reads the heap RAM and compares (up: the parent; down: the
// left child and, if there is one, the right child), all through the single
// read port of the heap RAM. Reset empties the heap at once; no clearing pass
// is needed. The result cannot be stalled; a new command is taken the cycle
// after done_o.
module indexed_min_heap_queue #(
  parameter int unsigned CAPACITY  = ihq_pkg::CAPACITY_DEF,
  parameter int unsigned ID_COUNT  = ihq_pkg::ID_COUNT_DEF,
  parameter int unsigned KEY_WIDTH = ihq_pkg::KEY_WIDTH_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  output logic                             busy_o,
  input  logic [2:0]                       op_i,
  input  logic [KEY_WIDTH-1:0]             key_i,
  input  logic [ihq_pkg::ID_FIELD_W-1:0]   id_i,
  input  logic [ihq_pkg::POS_FIELD_W-1:0]  position_i,
  output logic                             done_o,
  output logic [2:0]                       status_o,
  output logic                             found_o,
  output logic [KEY_WIDTH-1:0]             removed_key_o,
  output logic [ihq_pkg::ID_FIELD_W-1:0]   removed_id_o,
  output logic                             min_valid_o,
  output logic [KEY_WIDTH-1:0]             min_key_o,
  output logic [ihq_pkg::ID_FIELD_W-1:0]   min_id_o,
  output logic [ihq_pkg::TOTAL_W-1:0]      entry_total_o
);

  localparam int unsigned POS_W = $clog2(CAPACITY);
  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  localparam int unsigned ID_W  = $clog2(ID_COUNT);
  localparam int unsigned IDF_W = ihq_pkg::ID_FIELD_W;
  localparam int unsigned ENT_W = KEY_WIDTH + IDF_W;
  localparam int unsigned XW    = POS_W + 2;

  ihq_pkg::state_e  state_q, state_d;
  ihq_pkg::op_e     op_q, op_d;
  ihq_pkg::status_e status_q, status_d;

  logic [KEY_WIDTH-1:0]   key_q, key_d;
  logic [IDF_W-1:0]       id_q, id_d;
  logic [ihq_pkg::POS_FIELD_W-1:0] pos_q, pos_d;
  logic                   found_q, found_d;
  logic [KEY_WIDTH-1:0]   rkey_q, rkey_d;
  logic [IDF_W-1:0]       rid_q, rid_d;
  logic [CNT_W-1:0]       count_q, count_d;
  logic [ID_COUNT-1:0]    present_q, present_d;
  logic [KEY_WIDTH-1:0]   top_key_q, top_key_d;
  logic [IDF_W-1:0]       top_id_q, top_id_d;
  logic [POS_W-1:0]       i_q, i_d;
  logic [KEY_WIDTH-1:0]   ekey_q, ekey_d;
  logic [IDF_W-1:0]       eid_q, eid_d;
  logic [KEY_WIDTH-1:0]   ckey_q, ckey_d;
  logic [IDF_W-1:0]       cid_q, cid_d;
  logic                   moved_q, moved_d;
  logic                   down_ok_q, down_ok_d;
  logic [CNT_W-1:0]       scan_q, scan_d;
  logic                   pend_q, pend_d;

  logic                   heap_we, heap_re;
  logic [POS_W-1:0]       heap_waddr, heap_raddr;
  logic [ENT_W-1:0]       heap_wdata, heap_rdata;
  logic                   pmap_we, pmap_re;
  logic [ID_W-1:0]        pmap_waddr, pmap_raddr;
  logic [POS_W-1:0]       pmap_wdata, pmap_rdata;

  ihq_ram #(.WIDTH(ENT_W), .DEPTH(CAPACITY)) u_heap_ram (
    .clk_i   (clk_i),
    .we_i    (heap_we),
    .waddr_i (heap_waddr),
    .wdata_i (heap_wdata),
    .re_i    (heap_re),
    .raddr_i (heap_raddr),
    .rdata_o (heap_rdata)
  );

  ihq_ram #(.WIDTH(POS_W), .DEPTH(ID_COUNT)) u_pmap_ram (
    .clk_i   (clk_i),
    .we_i    (pmap_we),
    .waddr_i (pmap_waddr),
    .wdata_i (pmap_wdata),
    .re_i    (pmap_re),
    .raddr_i (pmap_raddr),
    .rdata_o (pmap_rdata)
  );

  // Shared decisions.
  logic [KEY_WIDTH-1:0] rd_key;
  logic [IDF_W-1:0]     rd_id;
  logic [ID_W-1:0]      idx;
  logic                 id_ok;
  logic [POS_W-1:0]     parent;
  logic [XW-1:0]        l_x, r_x, cnt_x;
  logic                 l_in, r_in, up_swap, l_less, r_win, need_down;
  logic                 dec_bad, dec_dup, scan_issue, scan_hit;
  logic [POS_W-1:0]     last_pos;
  logic [KEY_WIDTH-1:0] best_key;

  assign rd_key     = heap_rdata[ENT_W-1:IDF_W];
  assign rd_id      = heap_rdata[IDF_W-1:0];
  assign idx        = ID_W'(id_q);
  assign id_ok      = 32'(id_q) < ID_COUNT;
  assign parent     = POS_W'((i_q - 1'b1) >> 1);
  assign l_x        = XW'({i_q, 1'b1});
  assign r_x        = l_x + 1'b1;
  assign cnt_x      = XW'(count_q);
  assign l_in       = l_x < cnt_x;
  assign r_in       = r_x < cnt_x;
  assign up_swap    = rd_key > ekey_q;
  assign l_less     = ckey_q < ekey_q;
  assign best_key   = l_less ? ckey_q : ekey_q;
  assign r_win      = rd_key < best_key;
  // A remove whose filler already rose leaves a valid subtree below the gap.
  assign need_down  = down_ok_q && !moved_q;
  assign dec_bad    = key_q > rd_key;
  assign dec_dup    = (rd_id != id_q) && present_q[idx];
  assign scan_issue = scan_q < count_q;
  assign scan_hit   = pend_q && (rd_key == key_q) && (rd_id == id_q);
  assign last_pos   = POS_W'(count_q - 1'b1);

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ihq_pkg::ST_IDLE: begin
        if (start_i) state_d = ihq_pkg::ST_DECODE;
      end
      ihq_pkg::ST_DECODE: begin
        state_d = ihq_pkg::ST_DONE;
        case (op_q)
          ihq_pkg::OP_INSERT: begin
            if (id_ok && 32'(count_q) < CAPACITY && !present_q[idx]) begin
              state_d = ihq_pkg::ST_UP;
            end
          end
          ihq_pkg::OP_EXTRACT: begin
            if (count_q > CNT_W'(1)) state_d = ihq_pkg::ST_LAST;
          end
          ihq_pkg::OP_REMOVE: begin
            if (id_ok && present_q[idx]) state_d = ihq_pkg::ST_POS;
          end
          ihq_pkg::OP_DECREASE: begin
            if (32'(pos_q) < 32'(count_q)) state_d = ihq_pkg::ST_DEC;
          end
          ihq_pkg::OP_SEARCH: state_d = ihq_pkg::ST_SCAN;
          default: state_d = ihq_pkg::ST_DONE;
        endcase
      end
      ihq_pkg::ST_POS: begin
        state_d = (pmap_rdata == last_pos) ? ihq_pkg::ST_DONE : ihq_pkg::ST_LAST;
      end
      ihq_pkg::ST_LAST: state_d = ihq_pkg::ST_UP;
      ihq_pkg::ST_DEC: begin
        state_d = (dec_bad || !id_ok || dec_dup) ? ihq_pkg::ST_DONE : ihq_pkg::ST_UP;
      end
      ihq_pkg::ST_UP: begin
        if (i_q != '0) state_d = ihq_pkg::ST_UP_CMP;
        else state_d = need_down ? ihq_pkg::ST_DOWN : ihq_pkg::ST_PLACE;
      end
      ihq_pkg::ST_UP_CMP: begin
        if (up_swap) state_d = ihq_pkg::ST_UP;
        else state_d = need_down ? ihq_pkg::ST_DOWN : ihq_pkg::ST_PLACE;
      end
      ihq_pkg::ST_DOWN: state_d = l_in ? ihq_pkg::ST_DOWN_L : ihq_pkg::ST_PLACE;
      ihq_pkg::ST_DOWN_L: begin
        if (r_in) state_d = ihq_pkg::ST_DOWN_R;
        else state_d = (rd_key < ekey_q) ? ihq_pkg::ST_DOWN : ihq_pkg::ST_PLACE;
      end
      ihq_pkg::ST_DOWN_R: begin
        state_d = (r_win || l_less) ? ihq_pkg::ST_DOWN : ihq_pkg::ST_PLACE;
      end
      ihq_pkg::ST_PLACE: state_d = ihq_pkg::ST_DONE;
      ihq_pkg::ST_SCAN: begin
        if (scan_hit || (!scan_issue && !pend_q)) state_d = ihq_pkg::ST_DONE;
      end
      ihq_pkg::ST_DONE: state_d = ihq_pkg::ST_IDLE;
      default: state_d = ihq_pkg::ST_IDLE;
    endcase
  end

  // Datapath and memory commands.
  always_comb begin
    op_d       = op_q;
    key_d      = key_q;
    id_d       = id_q;
    pos_d      = pos_q;
    status_d   = status_q;
    found_d    = found_q;
    rkey_d     = rkey_q;
    rid_d      = rid_q;
    count_d    = count_q;
    present_d  = present_q;
    i_d        = i_q;
    ekey_d     = ekey_q;
    eid_d      = eid_q;
    ckey_d     = ckey_q;
    cid_d      = cid_q;
    moved_d    = moved_q;
    down_ok_d  = down_ok_q;
    scan_d     = scan_q;
    pend_d     = pend_q;
    heap_we    = 1'b0;
    heap_waddr = i_q;
    heap_wdata = heap_rdata;
    heap_re    = 1'b0;
    heap_raddr = '0;
    pmap_we    = 1'b0;
    pmap_waddr = ID_W'(rd_id);
    pmap_wdata = i_q;
    pmap_re    = 1'b0;
    pmap_raddr = idx;

    case (state_q)
      ihq_pkg::ST_IDLE: begin
        if (start_i) begin
          op_d     = ihq_pkg::op_e'(op_i);
          key_d    = key_i;
          id_d     = id_i;
          pos_d    = position_i;
          status_d = ihq_pkg::STAT_OK;
          found_d  = 1'b0;
          rkey_d   = '0;
          rid_d    = '0;
          moved_d  = 1'b0;
        end
      end
      ihq_pkg::ST_DECODE: begin
        case (op_q)
          ihq_pkg::OP_INSERT: begin
            if (!id_ok) status_d = ihq_pkg::STAT_NOTFOUND;
            else if (32'(count_q) >= CAPACITY) status_d = ihq_pkg::STAT_FULL;
            else if (present_q[idx]) status_d = ihq_pkg::STAT_DUP;
            else begin
              ekey_d         = key_q;
              eid_d          = id_q;
              i_d            = POS_W'(count_q);
              count_d        = count_q + 1'b1;
              present_d[idx] = 1'b1;
              down_ok_d      = 1'b0;
            end
          end
          ihq_pkg::OP_EXTRACT: begin
            if (count_q == '0) status_d = ihq_pkg::STAT_EMPTY;
            else begin
              rkey_d                     = top_key_q;
              rid_d                      = top_id_q;
              present_d[ID_W'(top_id_q)] = 1'b0;
              heap_re                    = 1'b1;
              heap_raddr                 = last_pos;
              i_d                        = '0;
              count_d                    = count_q - 1'b1;
              down_ok_d                  = 1'b1;
            end
          end
          ihq_pkg::OP_REMOVE: begin
            if (!id_ok || !present_q[idx]) status_d = ihq_pkg::STAT_NOTFOUND;
            else begin
              present_d[idx] = 1'b0;
              pmap_re        = 1'b1;
              down_ok_d      = 1'b1;
            end
          end
          ihq_pkg::OP_DECREASE: begin
            if (32'(pos_q) >= 32'(count_q)) status_d = ihq_pkg::STAT_BADPOS;
            else begin
              heap_re    = 1'b1;
              heap_raddr = POS_W'(pos_q);
            end
          end
          ihq_pkg::OP_SEARCH: begin
            scan_d = '0;
            pend_d = 1'b0;
          end
          default: status_d = ihq_pkg::STAT_OK;
        endcase
      end
      ihq_pkg::ST_POS: begin
        i_d     = pmap_rdata;
        count_d = count_q - 1'b1;
        if (pmap_rdata != last_pos) begin
          heap_re    = 1'b1;
          heap_raddr = last_pos;
        end
      end
      ihq_pkg::ST_LAST: begin
        ekey_d = rd_key;
        eid_d  = rd_id;
      end
      ihq_pkg::ST_DEC: begin
        if (dec_bad) status_d = ihq_pkg::STAT_BADPOS;
        else if (!id_ok) status_d = ihq_pkg::STAT_NOTFOUND;
        else if (dec_dup) status_d = ihq_pkg::STAT_DUP;
        else begin
          present_d[ID_W'(rd_id)] = 1'b0;
          present_d[idx]          = 1'b1;
          ekey_d                  = key_q;
          eid_d                   = id_q;
          i_d                     = POS_W'(pos_q);
          down_ok_d               = 1'b0;
        end
      end
      ihq_pkg::ST_UP: begin
        if (i_q != '0) begin
          heap_re    = 1'b1;
          heap_raddr = parent;
        end
      end
      ihq_pkg::ST_UP_CMP: begin
        if (up_swap) begin
          heap_we = 1'b1;
          pmap_we = 1'b1;
          i_d     = parent;
          moved_d = 1'b1;
        end
      end
      ihq_pkg::ST_DOWN: begin
        if (l_in) begin
          heap_re    = 1'b1;
          heap_raddr = POS_W'(l_x);
        end
      end
      ihq_pkg::ST_DOWN_L: begin
        ckey_d = rd_key;
        cid_d  = rd_id;
        if (r_in) begin
          heap_re    = 1'b1;
          heap_raddr = POS_W'(r_x);
        end else if (rd_key < ekey_q) begin
          heap_we = 1'b1;
          pmap_we = 1'b1;
          i_d     = POS_W'(l_x);
        end
      end
      ihq_pkg::ST_DOWN_R: begin
        if (r_win) begin
          heap_we = 1'b1;
          pmap_we = 1'b1;
          i_d     = POS_W'(r_x);
        end else if (l_less) begin
          heap_we    = 1'b1;
          heap_wdata = {ckey_q, cid_q};
          pmap_we    = 1'b1;
          pmap_waddr = ID_W'(cid_q);
          i_d        = POS_W'(l_x);
        end
      end
      ihq_pkg::ST_PLACE: begin
        heap_we    = 1'b1;
        heap_wdata = {ekey_q, eid_q};
        pmap_we    = 1'b1;
        pmap_waddr = ID_W'(eid_q);
      end
      ihq_pkg::ST_SCAN: begin
        if (scan_issue) begin
          heap_re    = 1'b1;
          heap_raddr = POS_W'(scan_q);
          scan_d     = scan_q + 1'b1;
        end
        pend_d = scan_issue;
        if (scan_hit) found_d = 1'b1;
      end
      default: status_d = status_q;
    endcase
  end

  // The heap top is mirrored in registers so the minimum is always on hand.
  always_comb begin
    top_key_d = top_key_q;
    top_id_d  = top_id_q;
    if (heap_we && heap_waddr == '0) begin
      top_key_d = heap_wdata[ENT_W-1:IDF_W];
      top_id_d  = heap_wdata[IDF_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ihq_pkg::ST_IDLE;
      status_q  <= ihq_pkg::STAT_OK;
      found_q   <= 1'b0;
      count_q   <= '0;
      present_q <= '0;
      moved_q   <= 1'b0;
      down_ok_q <= 1'b0;
      pend_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      status_q  <= status_d;
      found_q   <= found_d;
      count_q   <= count_d;
      present_q <= present_d;
      moved_q   <= moved_d;
      down_ok_q <= down_ok_d;
      pend_q    <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q      <= op_d;
    key_q     <= key_d;
    id_q      <= id_d;
    pos_q     <= pos_d;
    rkey_q    <= rkey_d;
    rid_q     <= rid_d;
    top_key_q <= top_key_d;
    top_id_q  <= top_id_d;
    i_q       <= i_d;
    ekey_q    <= ekey_d;
    eid_q     <= eid_d;
    ckey_q    <= ckey_d;
    cid_q     <= cid_d;
    scan_q    <= scan_d;
  end

  // Outputs.
  always_comb begin
    busy_o        = state_q != ihq_pkg::ST_IDLE;
    done_o        = state_q == ihq_pkg::ST_DONE;
    status_o      = status_q;
    found_o       = found_q;
    removed_key_o = rkey_q;
    removed_id_o  = rid_q;
    min_valid_o   = count_q != '0;
    min_key_o     = min_valid_o ? top_key_q : '0;
    min_id_o      = min_valid_o ? top_id_q : '0;
    entry_total_o = ihq_pkg::TOTAL_W'(count_q);
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(count_q) <= CAPACITY)
    else $error("entry count above capacity");

  a_write_in_heap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    heap_we |-> (XW'(heap_waddr) < cnt_x))
    else $error("heap write outside the occupied range");

  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe longer than one cycle");

  a_start_decode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> (state_q == ihq_pkg::ST_DECODE))
    else $error("accepted command not decoded");

endmodule

// ===== verif/indexed_min_heap_queue_test.sv =====
// Self-checking regression for the indexed min-heap queue with a behavioral heap predictor.
module indexed_min_heap_queue_test;

  localparam int unsigned CAP = 256;
  localparam int unsigned IDS = 256;
  localparam int unsigned WATCHDOG_LIMIT = 20000;

  typedef struct packed {
    logic [2:0]  op;
    logic [31:0] key;
    logic [7:0]  id;
    logic [7:0]  position;
  } command_t;

  typedef struct packed {
    logic [2:0]  status;
    logic        found;
    logic [31:0] removed_key;
    logic [7:0]  removed_id;
    logic        min_valid;
    logic [31:0] min_key;
    logic [7:0]  min_id;
    logic [8:0]  entry_total;
  } outcome_t;

  logic        clk_i, rst_ni, start_i, busy_o, done_o;
  logic [2:0]  op_i;
  logic [31:0] key_i;
  logic [7:0]  id_i, position_i;
  logic [2:0]  status_o;
  logic        found_o, min_valid_o;
  logic [31:0] removed_key_o, min_key_o;
  logic [7:0]  removed_id_o, min_id_o;
  logic [8:0]  entry_total_o;

  indexed_min_heap_queue uut (
    .clk_i, .rst_ni, .start_i, .busy_o, .op_i, .key_i, .id_i, .position_i,
    .done_o, .status_o, .found_o, .removed_key_o, .removed_id_o,
    .min_valid_o, .min_key_o, .min_id_o, .entry_total_o
  );

  // Predictor state.
  logic [31:0] pk [CAP];
  logic [7:0]  pid [CAP];
  int unsigned ppos [IDS];
  bit          pheld [IDS];
  int unsigned pcount;

  command_t pending_cmds[$];
  outcome_t expected_outcomes[$];
  int unsigned mismatches;
  int unsigned checked;
  int unsigned idle_pct;
  int unsigned watchdog;
  bit          hold_sender;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("MISMATCH %s: got %0h expected %0h (result %0d)", what, got, want, checked);
    mismatches++;
  endtask

  task automatic queue_cmd(input command_t c);
    pending_cmds = {pending_cmds, c};
  endtask

  function automatic void swap_slots(int unsigned a, int unsigned b);
    logic [31:0] k;
    logic [7:0]  d;
    k = pk[a]; d = pid[a];
    pk[a] = pk[b]; pid[a] = pid[b];
    pk[b] = k; pid[b] = d;
    ppos[pid[a]] = a;
    ppos[pid[b]] = b;
  endfunction

  function automatic void sift_up(int unsigned i);
    int unsigned p;
    while (i > 0) begin
      p = (i - 1) / 2;
      if (!(pk[p] > pk[i])) break;
      swap_slots(i, p);
      i = p;
    end
  endfunction

  function automatic void sift_down(int unsigned i);
    int unsigned l, r, s;
    forever begin
      l = 2 * i + 1;
      r = 2 * i + 2;
      s = i;
      if (l < pcount && pk[l] < pk[s]) s = l;
      if (r < pcount && pk[r] < pk[s]) s = r;
      if (s == i) break;
      swap_slots(i, s);
      i = s;
    end
  endfunction

  function automatic void take_out(int unsigned i);
    int unsigned last;
    last = pcount - 1;
    pheld[pid[i]] = 1'b0;
    if (i != last) begin
      pk[i] = pk[last];
      pid[i] = pid[last];
      ppos[pid[i]] = i;
    end
    pcount = last;
    if (i < pcount) begin
      sift_up(i);
      sift_down(i);
    end
  endfunction

  function automatic outcome_t predict_heap_op(input command_t c);
    outcome_t o;
    int unsigned i;
    o = '0;
    o.status = ihq_pkg::STAT_OK;
    case (c.op)
      ihq_pkg::OP_INSERT: begin
        if (pcount >= CAP) o.status = ihq_pkg::STAT_FULL;
        else if (pheld[c.id]) o.status = ihq_pkg::STAT_DUP;
        else begin
          i = pcount++;
          pk[i] = c.key; pid[i] = c.id;
          pheld[c.id] = 1'b1; ppos[c.id] = i;
          sift_up(i);
        end
      end
      ihq_pkg::OP_EXTRACT: begin
        if (pcount == 0) o.status = ihq_pkg::STAT_EMPTY;
        else begin
          o.removed_key = pk[0];
          o.removed_id = pid[0];
          take_out(0);
        end
      end
      ihq_pkg::OP_REMOVE: begin
        if (!pheld[c.id]) o.status = ihq_pkg::STAT_NOTFOUND;
        else take_out(ppos[c.id]);
      end
      ihq_pkg::OP_DECREASE: begin
        i = c.position;
        if (i >= pcount || c.key > pk[i]) o.status = ihq_pkg::STAT_BADPOS;
        else if (pid[i] != c.id && pheld[c.id]) o.status = ihq_pkg::STAT_DUP;
        else begin
          pheld[pid[i]] = 1'b0;
          pk[i] = c.key; pid[i] = c.id;
          pheld[c.id] = 1'b1; ppos[c.id] = i;
          sift_up(i);
        end
      end
      ihq_pkg::OP_SEARCH: begin
        for (i = 0; i < pcount; i++)
          if (pk[i] == c.key && pid[i] == c.id) begin
            o.found = 1'b1;
            break;
          end
      end
      default: ;
    endcase
    o.min_valid = pcount > 0;
    o.min_key = pcount > 0 ? pk[0] : '0;
    o.min_id = pcount > 0 ? pid[0] : '0;
    o.entry_total = pcount[8:0];
    return o;
  endfunction

  // Driver: takes the next pending command when the block is free.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start_i && !busy_o) begin
        expected_outcomes = {expected_outcomes, predict_heap_op(pending_cmds.pop_front())};
        start_i <= 1'b0;
      end else if (!start_i && pending_cmds.size() > 0 && !hold_sender &&
                   $urandom_range(99) >= idle_pct) begin
        start_i <= 1'b1;
        op_i <= pending_cmds[0].op;
        key_i <= pending_cmds[0].key;
        id_i <= pending_cmds[0].id;
        position_i <= pending_cmds[0].position;
      end
    end
  end

  // Monitor: every strobed result is compared with the oldest expectation.
  always @(posedge clk_i) begin
    outcome_t want;
    if (rst_ni) begin
      if (done_o || (start_i && !busy_o)) watchdog <= 0;
      else watchdog <= watchdog + 1;
      if (done_o) begin
        if (expected_outcomes.size() == 0) begin
          report_mismatch("unexpected result", '0, '0);
        end else begin
          want = expected_outcomes.pop_front();
          if (status_o !== want.status)
            report_mismatch("status", 32'(status_o), 32'(want.status));
          if (found_o !== want.found)
            report_mismatch("found", 32'(found_o), 32'(want.found));
          if (removed_key_o !== want.removed_key)
            report_mismatch("removed_key", removed_key_o, want.removed_key);
          if (removed_id_o !== want.removed_id)
            report_mismatch("removed_id", 32'(removed_id_o), 32'(want.removed_id));
          if (min_valid_o !== want.min_valid)
            report_mismatch("min_valid", 32'(min_valid_o), 32'(want.min_valid));
          if (min_key_o !== want.min_key) report_mismatch("min_key", min_key_o, want.min_key);
          if (min_id_o !== want.min_id)
            report_mismatch("min_id", 32'(min_id_o), 32'(want.min_id));
          if (entry_total_o !== want.entry_total)
            report_mismatch("entry_total", 32'(entry_total_o), 32'(want.entry_total));
          checked++;
        end
      end
      if (watchdog >= WATCHDOG_LIMIT) begin
        $display("watchdog expired with %0d results outstanding", expected_outcomes.size());
        $display("indexed_min_heap_queue regression: fail");
        $finish;
      end
    end
  end

  initial begin
    clk_i = 0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic command_t mk(input logic [2:0] op, input logic [31:0] key,
                                  input logic [7:0] id, input logic [7:0] position);
    command_t c;
    c.op = op; c.key = key; c.id = id; c.position = position;
    return c;
  endfunction

  // Random key: mostly a narrow range so that equal keys and ties occur.
  function automatic logic [31:0] rand_key();
    case ($urandom_range(3))
      0: return $urandom();
      1: return 32'hFFFF_FFF0 + $urandom_range(15);
      default: return $urandom_range(40);
    endcase
  endfunction

  function automatic command_t rand_cmd(input int unsigned fill_bias);
    command_t c;
    int unsigned r;
    c = mk(3'($urandom_range(4)), rand_key(), 8'($urandom_range(IDS - 1)),
           8'($urandom_range(255)));
    r = $urandom_range(99);
    if (r < fill_bias) c.op = ihq_pkg::OP_INSERT;
    else if (r < 97 && c.op == ihq_pkg::OP_INSERT)
      c.op = 3'($urandom_range(ihq_pkg::OP_SEARCH, ihq_pkg::OP_EXTRACT));
    else if (r >= 97) c.op = 3'($urandom_range(7, 5));
    // Decrease key mostly aims at a held position with a smaller key.
    if (c.op == ihq_pkg::OP_DECREASE && $urandom_range(3) != 0) begin
      c.position = 8'($urandom_range(31));
      c.key = $urandom_range(20);
    end
    return c;
  endfunction

  task automatic wait_drained();
    while (pending_cmds.size() > 0 || start_i || expected_outcomes.size() > 0)
      @(posedge clk_i);
    repeat (30) @(posedge clk_i);
  endtask

  initial begin
    int unsigned phase, n;
    rst_ni = 0; start_i = 0; op_i = '0; key_i = '0; id_i = '0; position_i = '0;
    mismatches = 0; checked = 0; idle_pct = 0; watchdog = 0;
    hold_sender = 0; pcount = 0;
    foreach (pheld[i]) pheld[i] = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1;

    // Directed: empty heap cases, field extremes, ties, duplicates, bad positions.
    queue_cmd(mk(ihq_pkg::OP_EXTRACT, '0, '0, '0));
    queue_cmd(mk(ihq_pkg::OP_REMOVE, '0, 8'hFF, '0));
    queue_cmd(mk(ihq_pkg::OP_DECREASE, '0, '0, '0));
    queue_cmd(mk(ihq_pkg::OP_INSERT, 32'hFFFF_FFFF, 8'hFF, 8'hFF));
    queue_cmd(mk(ihq_pkg::OP_INSERT, 32'h0, 8'h00, 8'h00));
    queue_cmd(mk(ihq_pkg::OP_INSERT, 32'h5, 8'h00, 8'h00));
    queue_cmd(mk(ihq_pkg::OP_INSERT, 32'h0, 8'h10, 8'h00));
    queue_cmd(mk(ihq_pkg::OP_INSERT, 32'h7, 8'h20, 8'h00));
    queue_cmd(mk(ihq_pkg::OP_SEARCH, 32'h0, 8'h10, 8'h00));
    queue_cmd(mk(ihq_pkg::OP_SEARCH, 32'h1, 8'h10, 8'h00));
    queue_cmd(mk(ihq_pkg::OP_DECREASE, 32'h3, 8'h21, 8'hFF));
    queue_cmd(mk(ihq_pkg::OP_DECREASE, 32'hFFFF_FFFF, 8'h21, 8'h01));
    queue_cmd(mk(ihq_pkg::OP_DECREASE, 32'h0, 8'h10, 8'h03));
    queue_cmd(mk(ihq_pkg::OP_DECREASE, 32'h0, 8'h33, 8'h03));
    queue_cmd(mk(3'd5, 32'hA5A5_A5A5, 8'h5A, 8'hA5));
    queue_cmd(mk(3'd7, '1, '1, '1));
    queue_cmd(mk(ihq_pkg::OP_REMOVE, '0, 8'h00, '0));
    queue_cmd(mk(ihq_pkg::OP_REMOVE, '0, 8'h00, '0));
    queue_cmd(mk(ihq_pkg::OP_EXTRACT, '0, '0, '0));
    queue_cmd(mk(ihq_pkg::OP_EXTRACT, '0, '0, '0));
    queue_cmd(mk(ihq_pkg::OP_EXTRACT, '0, '0, '0));
    queue_cmd(mk(ihq_pkg::OP_EXTRACT, '0, '0, '0));
    wait_drained();

    // Fill to capacity and try more, then drain by extraction.
    for (n = 0; n < CAP + 2; n++)
      queue_cmd(mk(ihq_pkg::OP_INSERT, rand_key(), n[7:0], 8'($urandom_range(255))));
    queue_cmd(mk(ihq_pkg::OP_DECREASE, 32'h0, 8'h07, 8'hFF));
    for (n = 0; n < CAP + 1; n++) queue_cmd(mk(ihq_pkg::OP_EXTRACT, '0, '0, '0));
    wait_drained();

    // Random phases with different idling of the sender.
    for (phase = 0; phase < 4; phase++) begin
      idle_pct = (phase == 1) ? 87 : (phase == 2) ? 6 : 0;
      for (n = 0; n < 230; n++) queue_cmd(rand_cmd(phase == 3 ? 70 : 40));
      if (phase == 2) begin
        // Let the block go idle with commands still pending before more arrive.
        while (pending_cmds.size() > 115) @(posedge clk_i);
        hold_sender = 1;
        while (start_i || expected_outcomes.size() > 0) @(posedge clk_i);
        repeat (5) @(posedge clk_i);
        hold_sender = 0;
      end
      wait_drained();
    end

    $display("Covered %0d results: directed edge cases, full heap, random mixes.", checked);
    if (mismatches == 0 && expected_outcomes.size() == 0) begin
      $display("indexed_min_heap_queue regression: pass");
    end else begin
      $display("indexed_min_heap_queue regression: fail");
    end
    $finish;
  end
endmodule

// ===== sim.f =====
hw/rtl/ihq_pkg.sv
hw/rtl/ihq_ram.sv
hw/rtl/indexed_min_heap_queue.sv
verif/indexed_min_heap_queue_test.sv
